### hdl/cav_pkg.sv
// Shared types for the cursor array list: operation codes and cell control.
package cav_pkg;

  // Operation codes carried by the mode field of an input word.
  typedef enum logic [3:0] {
    MODE_INSERT  = 4'd0,
    MODE_APPEND  = 4'd1,
    MODE_REMOVE  = 4'd2,
    MODE_READ    = 4'd3,
    MODE_START   = 4'd4,
    MODE_END     = 4'd5,
    MODE_BACK    = 4'd6,
    MODE_FORWARD = 4'd7,
    MODE_SETPOS  = 4'd8,
    MODE_CLEAR   = 4'd9
  } mode_e;

  // Width of the position and length fields.
  localparam int unsigned LenW  = 5;
  localparam int unsigned WordW = 32;

  // Broadcast to every cell in the cycle an operation is committed.
  typedef struct packed {
    logic do_insert;
    logic do_append;
    logic do_remove;
  } cell_ctl_t;

endpackage

### hdl/cursor_array_list_core.sv
// Top level of the cursor array list: operation decode, cell row and result register.
//
// Usage: each word on the input channel (in_valid_i / in_ready_o) carries one
// operation in mode_i, with value_i for insert and append and position_i for
// set position. Every accepted word yields exactly one result word on the
// output channel (out_valid_o / out_ready_i): ok_o, read_word_o, and the left
// and right lengths around the cursor after the operation.
// The result is registered and appears in the cycle after acceptance.
// One word is taken per cycle while the receiver keeps up. A row of CAPACITY
// cells, one entry each, shifts the entries from the cursor onward toward or
// away from the cursor in the same cycle as the operation is accepted.
// The result sits in an output register; a new word is taken whenever that
// register is empty or being drained in the same cycle. When the receiver
// stalls, the held result stays unchanged and in_ready_o drops until taken.
// Reset empties the list and puts the cursor at zero; entry storage itself is
// not cleared, and there is no clearing pass.
module cursor_array_list_core import cav_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [3:0]              mode_i,
  input  logic signed [WordW-1:0] value_i,
  input  logic [LenW-1:0]         position_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    ok_o,
  output logic signed [WordW-1:0] read_word_o,
  output logic [LenW-1:0]         left_length_o,
  output logic [LenW-1:0]         right_length_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > LenW) ? CntW : LenW;

  logic [CntW-1:0] count_q, count_d, cursor_q, cursor_d;
  logic            accept, full, has_cur;
  cell_ctl_t       ctl;
  logic            ok_d;
  logic signed [WordW-1:0] word_d, hit_word;
  logic [CmpW-1:0] pos_ext, cnt_ext, cur_ext, right_ext;

  logic signed [WordW-1:0] words    [CAPACITY];
  logic signed [WordW-1:0] hit_words[CAPACITY];

  logic                    out_valid_q;
  logic                    ok_q;
  logic signed [WordW-1:0] read_word_q;
  logic [LenW-1:0]         left_q, right_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(CAPACITY));
  assign has_cur    = (cursor_q < count_q);
  assign pos_ext    = CmpW'(position_i);
  assign cnt_ext    = CmpW'(count_q);

  // Row of cells; the ends see a zero neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WordW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    cav_cell #(
      .CntW (CntW),
      .Idx  (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .cursor_i     (cursor_q),
      .count_i      (count_q),
      .value_i      (value_i),
      .left_word_i  (left_w),
      .right_word_i (right_w),
      .word_o       (words[i]),
      .hit_word_o   (hit_words[i])
    );
  end

  // Only the cell under the cursor drives a nonzero word.
  always_comb begin
    hit_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_word = hit_word | hit_words[i];
    end
  end

  // Operation decode: next count, cursor, cell commands and the result.
  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    ctl      = '0;
    ok_d     = 1'b0;
    word_d   = '0;
    unique case (mode_e'(mode_i))
      MODE_INSERT: begin
        if (!full) begin
          ctl.do_insert = accept;
          count_d       = count_q + 1'b1;
          ok_d          = 1'b1;
        end
      end
      MODE_APPEND: begin
        if (!full) begin
          ctl.do_append = accept;
          count_d       = count_q + 1'b1;
          ok_d          = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (has_cur) begin
          ctl.do_remove = accept;
          count_d       = count_q - 1'b1;
          word_d        = hit_word;
          ok_d          = 1'b1;
        end
      end
      MODE_READ: begin
        if (has_cur) begin
          word_d = hit_word;
          ok_d   = 1'b1;
        end
      end
      MODE_START: begin
        cursor_d = '0;
        ok_d     = 1'b1;
      end
      MODE_END: begin
        cursor_d = count_q;
        ok_d     = 1'b1;
      end
      MODE_BACK: begin
        if (cursor_q != '0) begin
          cursor_d = cursor_q - 1'b1;
        end
        ok_d = 1'b1;
      end
      MODE_FORWARD: begin
        if (has_cur) begin
          cursor_d = cursor_q + 1'b1;
        end
        ok_d = 1'b1;
      end
      MODE_SETPOS: begin
        if (pos_ext <= cnt_ext) begin
          cursor_d = CntW'(pos_ext);
          ok_d     = 1'b1;
        end
      end
      MODE_CLEAR: begin
        count_d  = '0;
        cursor_d = '0;
        ok_d     = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  assign cur_ext   = CmpW'(cursor_d);
  assign right_ext = CmpW'(count_d) - CmpW'(cursor_d);

  // List state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q  <= count_d;
        cursor_q <= cursor_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q        <= ok_d;
      read_word_q <= word_d;
      left_q      <= cur_ext[LenW-1:0];
      right_q     <= right_ext[LenW-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign read_word_o    = read_word_q;
  assign left_length_o  = left_q;
  assign right_length_o = right_q;

endmodule

### hdl/cav_cell.sv
// One cell of the list: holds a single entry and shifts with its neighbors.
module cav_cell import cav_pkg::*; #(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  logic                    clk_i,
  input  cell_ctl_t               ctl_i,
  input  logic [CntW-1:0]         cursor_i,
  input  logic [CntW-1:0]         count_i,
  input  logic signed [WordW-1:0] value_i,
  input  logic signed [WordW-1:0] left_word_i,
  input  logic signed [WordW-1:0] right_word_i,
  output logic signed [WordW-1:0] word_o,
  output logic signed [WordW-1:0] hit_word_o
);

  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  logic signed [WordW-1:0] word_q, word_d;
  logic at_cur, after_cur, at_end;

  assign at_cur    = (cursor_i == IdxC);
  assign after_cur = (IdxC > cursor_i);
  assign at_end    = (count_i == IdxC);

  // Pick the next entry: new word, the left neighbor on insert, the right on remove.
  always_comb begin
    word_d = word_q;
    if (ctl_i.do_insert) begin
      if (at_cur) begin
        word_d = value_i;
      end else if (after_cur) begin
        word_d = left_word_i;
      end
    end else if (ctl_i.do_append) begin
      if (at_end) begin
        word_d = value_i;
      end
    end else if (ctl_i.do_remove) begin
      if (at_cur || after_cur) begin
        word_d = right_word_i;
      end
    end
  end

  // Entry storage needs no reset; unwritten entries are never read.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o     = word_q;
  assign hit_word_o = at_cur ? word_q : '0;

endmodule

### bench/cursor_array_list_checker.sv
// Checker for the cursor array list: tracks the list, predicts each result and compares.
`timescale 1ns / 100ps

module cursor_array_list_checker import cav_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [3:0]              mode_i,
  input  logic signed [WordW-1:0] value_i,
  input  logic [LenW-1:0]         position_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic                    ok_i,
  input  logic signed [WordW-1:0] read_word_i,
  input  logic [LenW-1:0]         left_length_i,
  input  logic [LenW-1:0]         right_length_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  // One result word as the block should produce it.
  typedef struct packed {
    logic             ok;
    logic [WordW-1:0] word;
    logic [LenW-1:0]  left;
    logic [LenW-1:0]  right;
  } list_result_t;

  // Shadow copy of the list contents, size and cursor.
  logic [WordW-1:0] list_mem [CAPACITY];
  logic [LenW-1:0]  list_count;
  logic [LenW-1:0]  list_cursor;
  list_result_t     expected_results [$];

  // Applies one operation to the shadow list and returns the result it gives.
  task automatic apply_list_op(input logic [3:0] op, input logic [WordW-1:0] word_in,
                               input logic [LenW-1:0] pos, output list_result_t res);
    res = '0;
    case (op)
      MODE_INSERT: begin
        if (list_count < CAPACITY) begin
          for (int i = list_count; i > list_cursor; i--) list_mem[i] = list_mem[i-1];
          list_mem[list_cursor] = word_in;
          list_count++;
          res.ok = 1'b1;
        end
      end
      MODE_APPEND: begin
        if (list_count < CAPACITY) begin
          list_mem[list_count] = word_in;
          list_count++;
          res.ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (list_cursor < list_count) begin
          res.word = list_mem[list_cursor];
          for (int i = list_cursor; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          list_count--;
          res.ok = 1'b1;
        end
      end
      MODE_READ: begin
        if (list_cursor < list_count) begin
          res.word = list_mem[list_cursor];
          res.ok   = 1'b1;
        end
      end
      MODE_START: begin
        list_cursor = '0;
        res.ok      = 1'b1;
      end
      MODE_END: begin
        list_cursor = list_count;
        res.ok      = 1'b1;
      end
      MODE_BACK: begin
        if (list_cursor != 0) list_cursor--;
        res.ok = 1'b1;
      end
      MODE_FORWARD: begin
        if (list_cursor < list_count) list_cursor++;
        res.ok = 1'b1;
      end
      MODE_SETPOS: begin
        if (pos <= list_count) begin
          list_cursor = pos;
          res.ok      = 1'b1;
        end
      end
      MODE_CLEAR: begin
        list_count  = '0;
        list_cursor = '0;
        res.ok      = 1'b1;
      end
      default: ;
    endcase
    res.left  = list_cursor;
    res.right = list_count - list_cursor;
  endtask

  // Reports one field that differs from its expected value.
  task automatic compare_field(input string field, input logic [WordW-1:0] exp_val,
                               input logic [WordW-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  // Retire results against the oldest expectation, then predict for the new word.
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_res;
    list_result_t new_res;
    if (!rst_ni) begin
      list_count  = '0;
      list_cursor = '0;
      expected_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with no expected result pending", $time);
          fail_count_o++;
        end else begin
          exp_res = expected_results.pop_front();
          compare_field("ok", exp_res.ok, ok_i);
          compare_field("read_word", exp_res.word, read_word_i);
          compare_field("left_length", exp_res.left, left_length_i);
          compare_field("right_length", exp_res.right, right_length_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_list_op(mode_i, value_i, position_i, new_res);
        expected_results.push_back(new_res);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

### bench/cursor_array_list_core_test.sv
// Testbench top for the cursor array list: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module cursor_array_list_core_test;
  import cav_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam logic [3:0] UNUSED_MODE_FIRST = 4'd10;
  localparam logic [3:0] UNUSED_MODE_LAST  = 4'd15;
  localparam int unsigned SEGMENTS      = 10;
  localparam int unsigned SEGMENT_WORDS = 40;
  localparam int unsigned LONG_HOLD     = 80;

  typedef enum logic [1:0] {BIAS_GROW, BIAS_SHRINK, BIAS_MIXED} bias_e;

  // Clock and known input levels from time zero.
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [3:0]              mode_i      = MODE_READ;
  logic signed [WordW-1:0] value_i     = '0;
  logic [LenW-1:0]         position_i  = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    ok_o;
  logic signed [WordW-1:0] read_word_o;
  logic [LenW-1:0]         left_length_o;
  logic [LenW-1:0]         right_length_o;
  int                      fail_count;
  int                      result_backlog;

  // Sender burst state and the request for one long receiver hold-off.
  int unsigned burst_left = 0;
  bit          no_gaps    = 0;
  bit          hold_req   = 0;

  cursor_array_list_core #(.CAPACITY(CAPACITY)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .value_i, .position_i,
    .out_valid_o, .out_ready_i, .ok_o, .read_word_o, .left_length_o, .right_length_o
  );

  cursor_array_list_checker #(.CAPACITY(CAPACITY)) checker_inst (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .value_i,
    .position_i, .out_valid_i(out_valid_o), .out_ready_i, .ok_i(ok_o),
    .read_word_i(read_word_o), .left_length_i(left_length_o),
    .right_length_i(right_length_o), .fail_count_o(fail_count),
    .pending_o(result_backlog)
  );

  always #5 clk_i = ~clk_i;

  // Run limit in case the block hangs.
  initial begin
    #2_000_000;
    $display("cursor_array_list_core_test: FAIL");
    $finish;
  end

  // Offers one word, with a random gap whenever a new burst starts unless gaps are off.
  task automatic send_item(input logic [3:0] op, input logic [WordW-1:0] word,
                           input logic [LenW-1:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      if (!no_gaps) begin
        repeat (gap) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i     <= op;
    value_i    <= word;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Picks an operation; growth and shrink phases steer the list to full and empty.
  function automatic logic [3:0] pick_mode(input bias_e bias);
    int unsigned roll = $urandom_range(0, 99);
    logic [3:0]  any_op = mode_e'($urandom_range(MODE_INSERT, MODE_CLEAR));
    if (roll < 4) return 4'($urandom_range(UNUSED_MODE_FIRST, UNUSED_MODE_LAST));
    case (bias)
      BIAS_GROW: begin
        if (roll < 50) return MODE_INSERT;
        if (roll < 75) return MODE_APPEND;
      end
      BIAS_SHRINK: begin
        if (roll < 50) return MODE_REMOVE;
        if (roll < 60) return MODE_BACK;
        if (roll < 65) return MODE_START;
      end
      default: ;
    endcase
    return any_op;
  endfunction

  // Mostly random words, with the extremes now and then.
  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Positions mostly from zero to one past the capacity, sometimes anywhere in the field.
  function automatic logic [LenW-1:0] pick_pos();
    if ($urandom_range(0, 7) == 0) return LenW'($urandom_range(0, 31));
    return LenW'($urandom_range(0, CAPACITY + 1));
  endfunction

  // Receiver: one long hold-off on request, otherwise a rotating stall pattern.
  initial begin
    int unsigned rx_cycle = 0;
    bit          held_once = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held_once) begin
        held_once = 1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
      end else begin
        rx_cycle++;
        case ((rx_cycle / 64) % 4)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= rx_cycle[2];
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    bias_e bias;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty list, cursor limits, word extremes, bad positions, unused modes.
    send_item(MODE_CLEAR, '0, '0);
    send_item(MODE_READ, '0, '0);
    send_item(MODE_REMOVE, '0, '0);
    send_item(MODE_BACK, '0, '0);
    send_item(MODE_FORWARD, '0, '0);
    send_item(MODE_SETPOS, '0, 5'd0);
    send_item(MODE_SETPOS, '0, 5'd31);
    send_item(MODE_INSERT, 32'h7FFF_FFFF, '0);
    send_item(MODE_INSERT, 32'h8000_0000, '0);
    send_item(MODE_APPEND, '0, '0);
    send_item(MODE_APPEND, 32'hFFFF_FFFF, 5'd31);
    send_item(MODE_READ, 32'hFFFF_FFFF, '0);
    send_item(MODE_FORWARD, '0, '0);
    send_item(MODE_REMOVE, '0, '0);
    send_item(MODE_END, '0, '0);
    send_item(MODE_READ, '0, '0);
    send_item(MODE_FORWARD, '0, '0);
    send_item(MODE_BACK, '0, '0);
    send_item(MODE_READ, '0, '0);
    send_item(MODE_START, '0, '0);
    send_item(MODE_SETPOS, '0, 5'd3);
    send_item(MODE_SETPOS, '0, 5'd4);
    send_item(UNUSED_MODE_FIRST, 32'h1234_5678, 5'd2);
    send_item(UNUSED_MODE_LAST, 32'hFFFF_FFFF, 5'd31);
    send_item(MODE_CLEAR, '0, '0);

    // Random phases; one runs without gaps against a long receiver hold-off,
    // and before another the sender waits for every result to drain.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 5)
        0, 3:    bias = BIAS_GROW;
        2:       bias = BIAS_SHRINK;
        default: bias = BIAS_MIXED;
      endcase
      if (seg == 2) begin
        no_gaps    = 1;
        burst_left = SEGMENT_WORDS;
        hold_req   = 1;
      end
      if (seg == 6) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (result_backlog != 0) @(negedge clk_i);
      end
      for (int n = 0; n < SEGMENT_WORDS; n++) begin
        send_item(pick_mode(bias), pick_word(), pick_pos());
      end
      no_gaps = 0;
    end

    // Drain and give the verdict.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (result_backlog != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("cursor_array_list_core_test: PASS");
    end else begin
      $display("cursor_array_list_core_test: FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/cav_pkg.sv
hdl/cav_cell.sv
hdl/cursor_array_list_core.sv
bench/cursor_array_list_checker.sv
bench/cursor_array_list_core_test.sv
